### hw/rtl/utf8v_pkg.sv
// utf8v_pkg: shared constants, rule codes and scan-state type for the UTF-8 validator.
// No dependencies; compile first.
package utf8v_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned TRAIL_W = 2;
    localparam int unsigned POS_W = 2;

    // Byte values that the checker compares against
    localparam logic [DATA_W-1:0] BOM_B0 = 8'hEF;
    localparam logic [DATA_W-1:0] BOM_B1 = 8'hBB;
    localparam logic [DATA_W-1:0] BOM_B2 = 8'hBF;
    localparam logic [DATA_W-1:0] CONT_LO = 8'h80;
    localparam logic [DATA_W-1:0] CONT_HI = 8'hBF;
    localparam logic [DATA_W-1:0] LEAD_MB = 8'hC0;
    localparam logic [DATA_W-1:0] LEAD_MIN = 8'hC2;
    localparam logic [DATA_W-1:0] LEAD_3B = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD_ED = 8'hED;
    localparam logic [DATA_W-1:0] LEAD_4B = 8'hF0;
    localparam logic [DATA_W-1:0] LEAD_MAX = 8'hF4;
    localparam logic [DATA_W-1:0] E0_LO = 8'hA0;
    localparam logic [DATA_W-1:0] ED_HI = 8'h9F;
    localparam logic [DATA_W-1:0] F0_LO = 8'h90;
    localparam logic [DATA_W-1:0] F4_HI = 8'h8F;

    // Bytes after which the position counter stops
    localparam logic [POS_W-1:0] POS_SAT = 2'd3;

    // Limit on the first continuation byte after a lead
    typedef enum logic [2:0] {
        RULE_ANY = 3'd0,   // 80-BF
        RULE_E0  = 3'd1,   // A0-BF
        RULE_ED  = 3'd2,   // 80-9F
        RULE_F0  = 3'd3,   // 90-BF
        RULE_F4  = 3'd4    // 80-8F
    } t_rule;

    // Per-stream scan state
    typedef struct packed {
        logic [TRAIL_W-1:0] trail;
        t_rule              rule;
        logic [POS_W-1:0]   pos;
        logic               bom;
        logic               err;
        logic               mb;
    } t_scan_state;

    // Verdict fields of one result
    typedef struct packed {
        logic is_utf8;
        logic well_formed;
        logic has_multibyte;
    } t_verdict;

    localparam t_scan_state SCAN_START = '{
        trail: '0,
        rule:  RULE_ANY,
        pos:   '0,
        bom:   1'b1,
        err:   1'b0,
        mb:    1'b0
    };

endpackage

### hw/rtl/utf8v_ifs.sv
// utf8v_ifs: valid/ready channel interfaces for bytes, results and configuration.
// Depends on utf8v_pkg for the data width.
interface utf8v_byte_if;
    logic                             valid;
    logic                             ready;
    logic [utf8v_pkg::DATA_W-1:0]     data_byte;
    logic                             last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_res_if;
    logic valid;
    logic ready;
    logic is_utf8;
    logic well_formed;
    logic has_multibyte;

    modport source (output valid, output is_utf8, output well_formed,
                    output has_multibyte, input ready);
    modport sink   (input valid, input is_utf8, input well_formed,
                    input has_multibyte, output ready);
endinterface

interface utf8v_cfg_if;
    logic valid;
    logic ready;
    logic default_utf8;

    modport source (output valid, output default_utf8, input ready);
    modport sink   (input valid, input default_utf8, output ready);
endinterface

### hw/rtl/utf8v_byte_check.sv
// utf8v_byte_check: next scan state and verdict for one byte, pure combinational.
// Depends on utf8v_pkg for the state struct, rule codes and byte constants.
module utf8v_byte_check (
    input  utf8v_pkg::t_scan_state          i_state,
    input  logic [utf8v_pkg::DATA_W-1:0]    i_byte,
    input  logic                            i_default_utf8,
    output utf8v_pkg::t_scan_state          o_state,
    output utf8v_pkg::t_verdict             o_verdict
);

    utf8v_pkg::t_scan_state s_bom;
    utf8v_pkg::t_scan_state s_chk;
    logic                   cont_ok;
    logic                   wf;
    logic                   mb;

    // Range check of a continuation byte under the pending rule
    always_comb begin
        unique case (i_state.rule)
            utf8v_pkg::RULE_E0: cont_ok = (i_byte >= utf8v_pkg::E0_LO) &&
                                          (i_byte <= utf8v_pkg::CONT_HI);
            utf8v_pkg::RULE_ED: cont_ok = (i_byte >= utf8v_pkg::CONT_LO) &&
                                          (i_byte <= utf8v_pkg::ED_HI);
            utf8v_pkg::RULE_F0: cont_ok = (i_byte >= utf8v_pkg::F0_LO) &&
                                          (i_byte <= utf8v_pkg::CONT_HI);
            utf8v_pkg::RULE_F4: cont_ok = (i_byte >= utf8v_pkg::CONT_LO) &&
                                          (i_byte <= utf8v_pkg::F4_HI);
            default:            cont_ok = (i_byte >= utf8v_pkg::CONT_LO) &&
                                          (i_byte <= utf8v_pkg::CONT_HI);
        endcase
    end

    // Track the leading byte-order mark; a broken mark counts its EF as multibyte
    always_comb begin
        s_bom = i_state;
        if (i_state.bom) begin
            priority if (i_state.pos == 2'd0) begin
                if (i_byte != utf8v_pkg::BOM_B0) begin
                    s_bom.bom = 1'b0;
                end
            end else if (i_state.pos == 2'd1) begin
                if (i_byte != utf8v_pkg::BOM_B1) begin
                    s_bom.bom = 1'b0;
                    s_bom.mb  = 1'b1;
                end
            end else if (i_state.pos == 2'd2) begin
                if (i_byte != utf8v_pkg::BOM_B2) begin
                    s_bom.bom = 1'b0;
                    s_bom.mb  = 1'b1;
                end
            end else begin
                s_bom.bom = i_state.bom;
            end
        end
    end

    // Check the byte as a continuation or as a lead; freeze after an error
    always_comb begin
        s_chk = s_bom;
        if (!i_state.err) begin
            if (i_state.trail != '0) begin
                if (!cont_ok) begin
                    s_chk.err = 1'b1;
                end
                s_chk.rule  = utf8v_pkg::RULE_ANY;
                s_chk.trail = i_state.trail - 2'd1;
            end else begin
                if ((i_byte >= utf8v_pkg::LEAD_MB) &&
                    !((i_state.pos == 2'd0) && (i_byte == utf8v_pkg::BOM_B0))) begin
                    s_chk.mb = 1'b1;
                end
                priority if (i_byte < utf8v_pkg::CONT_LO) begin
                    s_chk.err = 1'b0;
                end else if ((i_byte < utf8v_pkg::LEAD_MIN) ||
                             (i_byte > utf8v_pkg::LEAD_MAX)) begin
                    s_chk.err = 1'b1;
                end else if (i_byte < utf8v_pkg::LEAD_3B) begin
                    s_chk.trail = 2'd1;
                    s_chk.rule  = utf8v_pkg::RULE_ANY;
                end else if (i_byte < utf8v_pkg::LEAD_4B) begin
                    s_chk.trail = 2'd2;
                    s_chk.rule  = (i_byte == utf8v_pkg::LEAD_3B) ? utf8v_pkg::RULE_E0 :
                                  (i_byte == utf8v_pkg::LEAD_ED) ? utf8v_pkg::RULE_ED :
                                                                   utf8v_pkg::RULE_ANY;
                end else begin
                    s_chk.trail = 2'd3;
                    s_chk.rule  = (i_byte == utf8v_pkg::LEAD_4B)  ? utf8v_pkg::RULE_F0 :
                                  (i_byte == utf8v_pkg::LEAD_MAX) ? utf8v_pkg::RULE_F4 :
                                                                    utf8v_pkg::RULE_ANY;
                end
            end
        end
        // Advance the saturating position
        if (i_state.pos != utf8v_pkg::POS_SAT) begin
            s_chk.pos = i_state.pos + 2'd1;
        end
    end

    // Form the verdict as if this byte ended the stream
    assign wf = !s_chk.err && (s_chk.trail == '0);
    assign mb = s_chk.mb || (s_chk.bom && (s_chk.pos != utf8v_pkg::POS_SAT));

    assign o_state                 = s_chk;
    assign o_verdict.is_utf8       = wf && (mb || i_default_utf8);
    assign o_verdict.well_formed   = wf;
    assign o_verdict.has_multibyte = mb;

endmodule

### hw/rtl/utf8_stream_validator_core.sv
// utf8_stream_validator_core: top level of the streaming UTF-8 well-formedness checker.
// Depends on utf8v_pkg, utf8v_ifs and utf8v_byte_check.
//
//  Channel   Dir   Payload                                  Transfer when
//  i_in      in    data_byte[7:0], last_byte                valid && ready
//  o_out     out   is_utf8, well_formed, has_multibyte      valid && ready
//  i_cfg     in    default_utf8                             valid && ready (always ready)
//
// One byte per cycle while i_in.ready is high: each byte updates the scan registers
// in the cycle it transfers; a last byte loads the result register for the next cycle.
// i_in.ready drops only while a result waits and o_out.ready is low; draining the
// result and taking the next byte happen in the same cycle.
// Synchronous active-low reset returns to start of stream with default_utf8 cleared.
module utf8_stream_validator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8v_byte_if.sink           i_in,
    utf8v_res_if.source          o_out,
    utf8v_cfg_if.sink            i_cfg
);

    utf8v_pkg::t_scan_state r_state;
    utf8v_pkg::t_scan_state n_state;
    utf8v_pkg::t_verdict    n_verdict;
    utf8v_pkg::t_verdict    r_verdict;
    logic                   r_out_valid;
    logic                   r_default_utf8;
    logic                   in_xfer;

    // Take a byte whenever the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    utf8v_byte_check u_check (
        .i_state        (r_state),
        .i_byte         (i_in.data_byte),
        .i_default_utf8 (r_default_utf8),
        .o_state        (n_state),
        .o_verdict      (n_verdict)
    );

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_utf8 <= 1'b0;
        end else if (i_cfg.valid) begin
            r_default_utf8 <= i_cfg.default_utf8;
        end
    end

    // Advance the scan state; restart after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utf8v_pkg::SCAN_START;
        end else if (in_xfer) begin
            r_state <= i_in.last_byte ? utf8v_pkg::SCAN_START : n_state;
        end
    end

    // Hold the result until it transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the verdict on the last byte
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.last_byte) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.is_utf8       = r_verdict.is_utf8;
    assign o_out.well_formed   = r_verdict.well_formed;
    assign o_out.has_multibyte = r_verdict.has_multibyte;

endmodule
